FILE: hw/rtl/tqm_pkg.sv
// ----------------------------------------------------------------------------
// tqm_pkg
// Shared types, widths and codes of the timestamp ordered queue merge.
// ----------------------------------------------------------------------------
`default_nettype none

package tqm_pkg;

    // Default geometry
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int NUM_GROUPS_DEF  = 4;

    // Field widths
    localparam int TIME_W = 64;
    localparam int PAY_W  = 32;
    localparam int QID_W  = 3;
    localparam int GID_W  = 2;
    localparam int STAT_W = 3;
    localparam int MASK_W = 8;
    localparam int MAP_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MAP   = 1'b1;

    // Request kinds
    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd1;
    localparam logic [STAT_W-1:0] ST_ORDER    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_FINISHED = 3'd4;

    // One result item
    typedef struct packed {
        logic              has_sample;
        logic [STAT_W-1:0] status;
        logic [QID_W-1:0]  out_queue;
        logic [TIME_W-1:0] out_time;
        logic [PAY_W-1:0]  out_payload;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tqm_if.sv
// ----------------------------------------------------------------------------
// tqm_in_if / tqm_out_if
// Valid/ready channels for sample requests and merged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqm_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [tqm_pkg::QID_W-1:0]  queue_index;
    logic [tqm_pkg::GID_W-1:0]  group_index;
    logic [tqm_pkg::TIME_W-1:0] timestamp;
    logic [tqm_pkg::PAY_W-1:0]  payload;

    modport source (output valid, kind, queue_index, group_index, timestamp, payload,
                    input ready);
    modport sink   (input valid, kind, queue_index, group_index, timestamp, payload,
                    output ready);
endinterface

interface tqm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       has_sample;
    logic [tqm_pkg::STAT_W-1:0] status;
    logic [tqm_pkg::QID_W-1:0]  out_queue;
    logic [tqm_pkg::TIME_W-1:0] out_time;
    logic [tqm_pkg::PAY_W-1:0]  out_payload;
    logic                       last;

    modport source (output valid, has_sample, status, out_queue, out_time, out_payload,
                    last, input ready);
    modport sink   (input valid, has_sample, status, out_queue, out_time, out_payload,
                    last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tqm_ram.sv
// ----------------------------------------------------------------------------
// tqm_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_ram #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic                 re,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/timestamp_ordered_queue_merge_core.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_queue_merge_core
// Merges per-sensor sample queues into one time ordered result stream.
// ----------------------------------------------------------------------------
// Usage:
//   sample: request channel; kind 0 pushes (queue_index, timestamp, payload),
//     kind 1 finishes group group_index. ready is high only while idle.
//   merged: result channel; every request yields one or more results, the
//     final one marked by last. All results of a request carry its status.
//   cfg_we/cfg_index/cfg_data: register writes, only while idle.
// Flow: a push or finish is checked first, then each merge round scans the
//   queues in order, reading the head sample of each live non-empty queue
//   from the sample RAM, and stops early on a live unfinished empty queue;
//   after a full scan the earliest head is dispatched, dropped or held.
//   Results are buffered in a result RAM until the merge ends, then drained
//   one at a time through the output register, each after a result RAM read.
// Stall: a stalled receiver holds the output register; the drain waits.
// Reset: queues empty, flags and start-time valid bits cleared; the sample RAM needs
//   no clearing pass since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_ordered_queue_merge_core #(
    parameter int NUM_QUEUES  = tqm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = tqm_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_GROUPS  = tqm_pkg::NUM_GROUPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tqm_in_if.sink                              sample,
    tqm_out_if.source                           merged,
    input  wire logic                           cfg_we,
    input  wire logic [tqm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tqm_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tqm_pkg::*;

    localparam int NQ  = NUM_QUEUES;
    localparam int QD  = QUEUE_DEPTH;
    localparam int NG  = NUM_GROUPS;
    localparam int QW  = $clog2(NQ);
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW  = $clog2(QD);
    localparam int CW  = $clog2(QD + 1);
    localparam int SW  = $clog2(NQ + 1);
    localparam int MD  = NQ * QD;
    localparam int AW  = $clog2(MD);
    localparam int RCW = $clog2(MD + 1);
    localparam int SMW = TIME_W + PAY_W;
    localparam int RBW = QID_W + TIME_W + PAY_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PUSH   = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_WAIT   = 10'b0000001000,
        S_DECIDE = 10'b0000010000,
        S_NEXT   = 10'b0000100000,
        S_DONE   = 10'b0001000000,
        S_EMPTY  = 10'b0010000000,
        S_DRD    = 10'b0100000000,
        S_DLD    = 10'b1000000000
    } state_t;

    // Fold a two bit group field onto the group count
    function automatic logic [GW-1:0] gwrap(input logic [1:0] v);
        logic [2:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 3; i++)
        begin
            if (32'(r) >= NG)
            begin
                r = r - 3'(NG);
            end
        end
        return GW'(r);
    endfunction

    // Sample RAM address of entry k behind the head of queue q
    function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] q,
                                              input logic [PW-1:0] hp,
                                              input logic [CW-1:0] k);
        logic [31:0] s;
        s = 32'(hp) + 32'(k);
        if (s >= QD)
        begin
            s = s - QD;
        end
        return AW'(32'(q) * QD + s);
    endfunction

    // Registers
    state_t               state_reg, state_next;
    logic [MASK_W-1:0]    active_mask_reg, active_mask_next;
    logic [MAP_W-1:0]     group_map_reg, group_map_next;
    logic [PW-1:0]        hp_reg [NQ];
    logic [PW-1:0]        hp_next [NQ];
    logic [CW-1:0]        fill_reg [NQ];
    logic [CW-1:0]        fill_next [NQ];
    logic [NQ-1:0]        fin_reg, fin_next;
    logic [NQ-1:0]        ret_reg, ret_next;
    logic [TIME_W-1:0]    gst_reg [NG];
    logic [TIME_W-1:0]    gst_next [NG];
    logic [NG-1:0]        gsv_reg, gsv_next;
    logic [TIME_W-1:0]    gmax_reg [NG];
    logic [TIME_W-1:0]    gmax_next [NG];
    logic [TIME_W-1:0]    last_sent_reg, last_sent_next;
    logic                 kind_reg, kind_next;
    logic [QW-1:0]        qsel_reg, qsel_next;
    logic [GW-1:0]        gsel_reg, gsel_next;
    logic [TIME_W-1:0]    ts_reg, ts_next;
    logic [PAY_W-1:0]     pay_reg, pay_next;
    logic [STAT_W-1:0]    st_reg, st_next;
    logic [SW-1:0]        scan_reg, scan_next;
    logic [QW-1:0]        pend_reg, pend_next;
    logic                 best_v_reg, best_v_next;
    logic [QW-1:0]        best_q_reg, best_q_next;
    logic [TIME_W-1:0]    best_t_reg, best_t_next;
    logic [PAY_W-1:0]     best_p_reg, best_p_next;
    logic [TIME_W-1:0]    cs_reg, cs_next;
    logic [RCW-1:0]       wcnt_reg, wcnt_next;
    logic [RCW-1:0]       rd_reg, rd_next;
    res_t                 out_reg, out_next;
    logic                 out_v_reg, out_v_next;

    // Memory ports
    logic                 sm_we, sm_re;
    logic [AW-1:0]        sm_waddr, sm_raddr;
    logic [SMW-1:0]       sm_wdata, sm_rdata;
    logic                 rb_we, rb_re;
    logic [AW-1:0]        rb_waddr, rb_raddr;
    logic [RBW-1:0]       rb_wdata, rb_rdata;

    // Per-queue views of the configuration
    logic [NQ-1:0]        live;
    logic [GW-1:0]        grp [NQ];

    for (genvar q = 0; q < NQ; q++)
    begin : g_queue
        if (q < MASK_W)
        begin : g_cfg
            assign live[q] = active_mask_reg[q] & ~ret_reg[q];
            assign grp[q]  = gwrap(group_map_reg[2*q +: 2]);
        end
        else
        begin : g_none
            assign live[q] = 1'b0;
            assign grp[q]  = '0;
        end
    end

    tqm_ram #(.W(SMW), .D(MD)) u_sample_ram (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    tqm_ram #(.W(RBW), .D(MD)) u_result_ram (
        .clk   (clk),
        .we    (rb_we),
        .waddr (rb_waddr),
        .wdata (rb_wdata),
        .re    (rb_re),
        .raddr (rb_raddr),
        .rdata (rb_rdata)
    );

    assign sample.ready       = (state_reg == S_IDLE);
    assign merged.valid       = out_v_reg;
    assign merged.has_sample  = out_reg.has_sample;
    assign merged.status      = out_reg.status;
    assign merged.out_queue   = out_reg.out_queue;
    assign merged.out_time    = out_reg.out_time;
    assign merged.out_payload = out_reg.out_payload;
    assign merged.last        = out_reg.last;

    // Next state logic
    always_comb
    begin
        logic              in_range;
        logic [QW-1:0]     qi;
        logic [GW-1:0]     g;
        logic [NQ-1:0]     gmask;
        logic [TIME_W-1:0] h;
        logic [TIME_W-1:0] cs;
        logic              do_pop;
        logic              do_emit;
        logic              do_scan;
        logic              out_free;

        state_next       = state_reg;
        active_mask_next = active_mask_reg;
        group_map_next   = group_map_reg;
        hp_next          = hp_reg;
        fill_next        = fill_reg;
        fin_next         = fin_reg;
        ret_next         = ret_reg;
        gst_next         = gst_reg;
        gsv_next         = gsv_reg;
        gmax_next        = gmax_reg;
        last_sent_next   = last_sent_reg;
        kind_next        = kind_reg;
        qsel_next        = qsel_reg;
        gsel_next        = gsel_reg;
        ts_next          = ts_reg;
        pay_next         = pay_reg;
        st_next          = st_reg;
        scan_next        = scan_reg;
        pend_next        = pend_reg;
        best_v_next      = best_v_reg;
        best_q_next      = best_q_reg;
        best_t_next      = best_t_reg;
        best_p_next      = best_p_reg;
        cs_next          = cs_reg;
        wcnt_next        = wcnt_reg;
        rd_next          = rd_reg;
        out_next         = out_reg;
        out_v_next       = out_v_reg;

        sm_we    = 1'b0;
        sm_waddr = '0;
        sm_wdata = '0;
        sm_re    = 1'b0;
        sm_raddr = '0;
        rb_we    = 1'b0;
        rb_waddr = '0;
        rb_wdata = '0;
        rb_re    = 1'b0;
        rb_raddr = '0;

        in_range = 1'b0;
        qi       = '0;
        g        = '0;
        gmask    = '0;
        h        = '0;
        cs       = '0;
        do_pop   = 1'b0;
        do_emit  = 1'b0;
        do_scan  = 1'b0;
        out_free = !out_v_reg || merged.ready;

        // Drop the output register once taken
        if (out_v_reg && merged.ready)
        begin
            out_v_next = 1'b0;
        end

        // Register writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_MASK: active_mask_next = cfg_data[MASK_W-1:0];
                CFG_GROUP_MAP:   group_map_next   = cfg_data[MAP_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    kind_next = sample.kind;
                    ts_next   = sample.timestamp;
                    pay_next  = sample.payload;
                    st_next   = ST_OK;
                    wcnt_next = '0;
                    in_range  = 32'(sample.queue_index) < NQ;
                    qi        = QW'(32'(sample.queue_index));
                    g         = gwrap(sample.group_index);
                    qsel_next = qi;
                    gsel_next = g;
                    if (sample.kind == KIND_PUSH)
                    begin
                        if (!in_range || !live[qi])
                        begin
                            st_next    = ST_UNKNOWN;
                            state_next = S_DONE;
                        end
                        else if (fin_reg[qi])
                        begin
                            st_next    = ST_FINISHED;
                            state_next = S_DONE;
                        end
                        else if (fill_reg[qi] != '0)
                        begin
                            // Fetch the newest sample for the order check
                            sm_re      = 1'b1;
                            sm_raddr   = addr_of(qi, hp_reg[qi], fill_reg[qi] - 1'b1);
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            sm_we         = 1'b1;
                            sm_waddr      = addr_of(qi, hp_reg[qi], '0);
                            sm_wdata      = {sample.timestamp, sample.payload};
                            fill_next[qi] = fill_reg[qi] + 1'b1;
                            do_scan       = 1'b1;
                        end
                    end
                    else
                    begin
                        for (int q = 0; q < NQ; q++)
                        begin
                            gmask[q] = live[q] && (grp[q] == g);
                        end
                        if ((gmask & ~fin_reg) == '0)
                        begin
                            st_next    = ST_UNKNOWN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            fin_next = fin_reg | gmask;
                            do_scan  = 1'b1;
                        end
                    end
                end
            end

            S_PUSH:
            begin
                if (sm_rdata[SMW-1:PAY_W] > ts_reg)
                begin
                    st_next    = ST_ORDER;
                    state_next = S_DONE;
                end
                else if (32'(fill_reg[qsel_reg]) >= QD)
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    sm_we               = 1'b1;
                    sm_waddr            = addr_of(qsel_reg, hp_reg[qsel_reg],
                                                  fill_reg[qsel_reg]);
                    sm_wdata            = {ts_reg, pay_reg};
                    fill_next[qsel_reg] = fill_reg[qsel_reg] + 1'b1;
                    do_scan             = 1'b1;
                end
            end

            S_SCAN:
            begin
                if (scan_reg == SW'(NQ))
                begin
                    state_next = best_v_reg ? S_DECIDE : S_DONE;
                end
                else
                begin
                    qi = scan_reg[QW-1:0];
                    if (!live[qi])
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                    else if (fill_reg[qi] == '0)
                    begin
                        // Retire a finished empty queue, stop on a live empty one
                        if (fin_reg[qi])
                        begin
                            ret_next[qi] = 1'b1;
                            scan_next    = scan_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        sm_re      = 1'b1;
                        sm_raddr   = addr_of(qi, hp_reg[qi], '0);
                        pend_next  = qi;
                        state_next = S_WAIT;
                    end
                end
            end

            S_WAIT:
            begin
                h = sm_rdata[SMW-1:PAY_W];
                g = grp[pend_reg];
                if (h > gmax_reg[g])
                begin
                    gmax_next[g] = h;
                end
                if (!best_v_reg || h < best_t_reg)
                begin
                    best_v_next = 1'b1;
                    best_q_next = pend_reg;
                    best_t_next = h;
                    best_p_next = sm_rdata[PAY_W-1:0];
                end
                scan_next  = scan_reg + 1'b1;
                state_next = S_SCAN;
            end

            S_DECIDE:
            begin
                g  = grp[best_q_reg];
                cs = gsv_reg[g] ? gst_reg[g] : gmax_reg[g];
                if (best_t_reg < last_sent_reg)
                begin
                    // Discard a sample behind the merge point
                    do_pop  = 1'b1;
                    st_next = ST_ORDER;
                    do_scan = 1'b1;
                end
                else
                begin
                    if (!gsv_reg[g])
                    begin
                        gst_next[g] = gmax_reg[g];
                        gsv_next[g] = 1'b1;
                    end
                    if (best_t_reg >= cs)
                    begin
                        do_pop  = 1'b1;
                        do_emit = 1'b1;
                        do_scan = 1'b1;
                    end
                    else if (fill_reg[best_q_reg] < CW'(2))
                    begin
                        if (!fin_reg[best_q_reg])
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            do_pop  = 1'b1;
                            do_emit = 1'b1;
                            do_scan = 1'b1;
                        end
                    end
                    else
                    begin
                        // Keep the sample only if its successor passes the start
                        sm_re      = 1'b1;
                        sm_raddr   = addr_of(best_q_reg, hp_reg[best_q_reg], CW'(1));
                        do_pop     = 1'b1;
                        cs_next    = cs;
                        state_next = S_NEXT;
                    end
                end
            end

            S_NEXT:
            begin
                if (sm_rdata[SMW-1:PAY_W] > cs_reg)
                begin
                    do_emit = 1'b1;
                end
                do_scan = 1'b1;
            end

            S_DONE:
            begin
                if (kind_reg == KIND_FINISH && st_reg != ST_UNKNOWN)
                begin
                    gsv_next[gsel_reg] = 1'b0;
                end
                rd_next    = '0;
                state_next = (wcnt_reg == '0) ? S_EMPTY : S_DRD;
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_next.has_sample  = 1'b0;
                    out_next.status      = st_reg;
                    out_next.out_queue   = '0;
                    out_next.out_time    = '0;
                    out_next.out_payload = '0;
                    out_next.last        = 1'b1;
                    out_v_next           = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_DRD:
            begin
                if (out_free)
                begin
                    rb_re      = 1'b1;
                    rb_raddr   = rd_reg[AW-1:0];
                    state_next = S_DLD;
                end
            end

            S_DLD:
            begin
                out_next.has_sample  = 1'b1;
                out_next.status      = st_reg;
                out_next.out_queue   = rb_rdata[RBW-1:TIME_W+PAY_W];
                out_next.out_time    = rb_rdata[TIME_W+PAY_W-1:PAY_W];
                out_next.out_payload = rb_rdata[PAY_W-1:0];
                out_next.last        = (rd_reg + 1'b1 == wcnt_reg);
                out_v_next           = 1'b1;
                rd_next              = rd_reg + 1'b1;
                state_next           = (rd_reg + 1'b1 == wcnt_reg) ? S_IDLE : S_DRD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance the head of the chosen queue
        if (do_pop)
        begin
            if (32'(hp_reg[best_q_reg]) + 1 >= QD)
            begin
                hp_next[best_q_reg] = '0;
            end
            else
            begin
                hp_next[best_q_reg] = hp_reg[best_q_reg] + 1'b1;
            end
            fill_next[best_q_reg] = fill_reg[best_q_reg] - 1'b1;
        end

        // Buffer a dispatched sample until the status is settled
        if (do_emit)
        begin
            rb_we          = 1'b1;
            rb_waddr       = wcnt_reg[AW-1:0];
            rb_wdata       = {QID_W'(32'(best_q_reg)), best_t_reg, best_p_reg};
            wcnt_next      = wcnt_reg + 1'b1;
            last_sent_next = best_t_reg;
        end

        // Start a new scan round
        if (do_scan)
        begin
            scan_next   = '0;
            best_v_next = 1'b0;
            for (int i = 0; i < NG; i++)
            begin
                gmax_next[i] = '0;
            end
            state_next  = S_SCAN;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_mask_reg <= '0;
            group_map_reg   <= '0;
            for (int i = 0; i < NQ; i++)
            begin
                hp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
            fin_reg       <= '0;
            ret_reg       <= '0;
            gsv_reg       <= '0;
            last_sent_reg <= '0;
            out_v_reg     <= 1'b0;
            wcnt_reg      <= '0;
            rd_reg        <= '0;
            scan_reg      <= '0;
            best_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_mask_reg <= active_mask_next;
            group_map_reg   <= group_map_next;
            hp_reg          <= hp_next;
            fill_reg        <= fill_next;
            fin_reg         <= fin_next;
            ret_reg         <= ret_next;
            gsv_reg         <= gsv_next;
            last_sent_reg   <= last_sent_next;
            out_v_reg       <= out_v_next;
            wcnt_reg        <= wcnt_next;
            rd_reg          <= rd_next;
            scan_reg        <= scan_next;
            best_v_reg      <= best_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        gst_reg    <= gst_next;
        gmax_reg   <= gmax_next;
        kind_reg   <= kind_next;
        qsel_reg   <= qsel_next;
        gsel_reg   <= gsel_next;
        ts_reg     <= ts_next;
        pay_reg    <= pay_next;
        st_reg     <= st_next;
        pend_reg   <= pend_next;
        best_q_reg <= best_q_next;
        best_t_reg <= best_t_next;
        best_p_reg <= best_p_next;
        cs_reg     <= cs_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tqm_checker.sv
// ----------------------------------------------------------------------------
// tqm_checker
// Port level checks of the queue merge core, bound to the merge core module.
// ----------------------------------------------------------------------------
`default_nettype none

module tqm_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         has_sample,
    input wire logic [tqm_pkg::STAT_W-1:0]   status,
    input wire logic [tqm_pkg::QID_W-1:0]    out_queue,
    input wire logic [tqm_pkg::TIME_W-1:0]   out_time,
    input wire logic [tqm_pkg::PAY_W-1:0]    out_payload,
    input wire logic                         last
);

    import tqm_pkg::*;

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Block further requests while one is in work
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in work");

    // An empty result closes its request and carries no sample
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_sample |-> last && out_time == '0 && out_payload == '0
        && out_queue == '0)
        else $error("empty result not final or not zeroed");

    // Status stays within the defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_UNKNOWN || status == ST_ORDER
        || status == ST_FULL || status == ST_FINISHED)
        else $error("undefined status code");

endmodule

bind timestamp_ordered_queue_merge_core tqm_checker u_tqm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (merged.valid),
    .out_ready   (merged.ready),
    .has_sample  (merged.has_sample),
    .status      (merged.status),
    .out_queue   (merged.out_queue),
    .out_time    (merged.out_time),
    .out_payload (merged.out_payload),
    .last        (merged.last)
);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the timestamp ordered queue merge core against a cycle-free
// prediction of its results. Requests are driven with random gaps, results
// are taken with random back-pressure, and every result is compared field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tqm_pkg::*;

    localparam int NQ        = NUM_QUEUES_DEF;
    localparam int DEPTH     = QUEUE_DEPTH_DEF;
    localparam int NG        = NUM_GROUPS_DEF;
    localparam int IDLE_LIMIT = 40000;

    // Predicts the merged result stream and checks what the core returns
    class merge_scoreboard;
        logic [MASK_W-1:0] active;
        logic [MAP_W-1:0]  gmap;
        logic [TIME_W-1:0] tstore [NQ*DEPTH];
        logic [PAY_W-1:0]  pstore [NQ*DEPTH];
        int unsigned       head [NQ];
        int unsigned       fill [NQ];
        logic [NQ-1:0]     fin_f;
        logic [NQ-1:0]     ret_f;
        logic [TIME_W-1:0] gstart [NG];
        logic [NG-1:0]     gstart_ok;
        logic [TIME_W-1:0] last_sent;
        res_t              expected_q [$];
        res_t              round_q [$];
        int                errors;

        function new();
            active    = '0;
            gmap      = '0;
            fin_f     = '0;
            ret_f     = '0;
            gstart_ok = '0;
            last_sent = '0;
            errors    = 0;
            foreach (head[q])
            begin
                head[q] = 0;
                fill[q] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ACTIVE_MASK)
                active = data[MASK_W-1:0];
            else
                gmap = data[MAP_W-1:0];
        endfunction

        function bit live(int q);
            return active[q] && !ret_f[q];
        endfunction

        function int grp(int q);
            return int'(gmap[2*q +: 2]) % NG;
        endfunction

        function int slot(int q, int unsigned k);
            return q * DEPTH + int'((head[q] + k) % DEPTH);
        endfunction

        function logic [TIME_W-1:0] head_time(int q);
            return tstore[slot(q, 0)];
        endfunction

        function void pop(int q, output logic [TIME_W-1:0] t, output logic [PAY_W-1:0] p);
            t = tstore[slot(q, 0)];
            p = pstore[slot(q, 0)];
            head[q] = (head[q] + 1) % DEPTH;
            fill[q]--;
        endfunction

        function void emit(int q, logic [TIME_W-1:0] t, logic [PAY_W-1:0] p);
            res_t r;
            r.has_sample  = 1'b1;
            r.status      = ST_OK;
            r.out_queue   = q[QID_W-1:0];
            r.out_time    = t;
            r.out_payload = p;
            r.last        = 1'b0;
            round_q.insert(round_q.size(), r);
            last_sent = t;
        endfunction

        // Latch the group start time on first use: latest head of its queues
        function logic [TIME_W-1:0] start_time(int g);
            logic [TIME_W-1:0] m;
            m = '0;
            if (gstart_ok[g])
                return gstart[g];
            for (int q = 0; q < NQ; q++)
                if (live(q) && grp(q) == g && fill[q] != 0 && head_time(q) > m)
                    m = head_time(q);
            gstart[g]    = m;
            gstart_ok[g] = 1'b1;
            return m;
        endfunction

        // Dispatch earliest heads while no live unfinished queue is empty
        function logic [STAT_W-1:0] merge();
            logic [STAT_W-1:0] st;
            logic [TIME_W-1:0] t;
            logic [TIME_W-1:0] cs;
            logic [PAY_W-1:0]  p;
            int                best;
            bit                fin;
            st = ST_OK;
            while (1)
            begin
                best = -1;
                for (int q = 0; q < NQ; q++)
                begin
                    if (!live(q))
                        continue;
                    if (fill[q] == 0)
                    begin
                        if (fin_f[q])
                        begin
                            ret_f[q] = 1'b1;
                            continue;
                        end
                        return st;
                    end
                    if (best < 0 || head_time(q) < head_time(best))
                        best = q;
                end
                if (best < 0)
                    return st;
                fin = fin_f[best];
                t   = head_time(best);
                // drop samples that would run the stream backwards
                if (t < last_sent)
                begin
                    pop(best, t, p);
                    st = ST_ORDER;
                    continue;
                end
                cs = start_time(grp(best));
                if (t >= cs)
                begin
                    pop(best, t, p);
                    emit(best, t, p);
                    continue;
                end
                // before the start: keep only the last sample ahead of it
                if (fill[best] < 2)
                begin
                    if (!fin)
                        return st;
                    pop(best, t, p);
                    emit(best, t, p);
                    continue;
                end
                pop(best, t, p);
                if (head_time(best) > cs)
                    emit(best, t, p);
            end
        endfunction

        // Note one accepted request and queue up the results it causes
        function void note_request(logic kind, logic [QID_W-1:0] qi, logic [GID_W-1:0] gi,
                                   logic [TIME_W-1:0] ts, logic [PAY_W-1:0] pay);
            logic [STAT_W-1:0] st;
            int                q;
            int                g;
            bit                known;
            res_t              r;
            round_q.delete();
            q = int'(qi);
            g = int'(gi) % NG;
            known = 0;
            if (kind == KIND_PUSH)
            begin
                if (!live(q))
                    st = ST_UNKNOWN;
                else if (fin_f[q])
                    st = ST_FINISHED;
                else if (fill[q] != 0 && tstore[slot(q, fill[q] - 1)] > ts)
                    st = ST_ORDER;
                else if (fill[q] >= DEPTH)
                    st = ST_FULL;
                else
                begin
                    tstore[slot(q, fill[q])] = ts;
                    pstore[slot(q, fill[q])] = pay;
                    fill[q]++;
                    st = merge();
                end
            end
            else
            begin
                for (int k = 0; k < NQ; k++)
                    if (live(k) && grp(k) == g && !fin_f[k])
                        known = 1;
                if (!known)
                    st = ST_UNKNOWN;
                else
                begin
                    for (int k = 0; k < NQ; k++)
                        if (live(k) && grp(k) == g)
                            fin_f[k] = 1'b1;
                    st = merge();
                    gstart_ok[g] = 1'b0;
                end
            end
            if (round_q.size() == 0)
            begin
                r = '0;
                round_q.insert(0, r);
            end
            foreach (round_q[i])
                round_q[i].status = st;
            round_q[round_q.size()-1].last = 1'b1;
            foreach (round_q[i])
                expected_q.insert(expected_q.size(), round_q[i]);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.has_sample !== want.has_sample || got.status !== want.status ||
                got.out_queue !== want.out_queue || got.out_time !== want.out_time ||
                got.out_payload !== want.out_payload || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tqm_in_if  sample_ch ();
    tqm_out_if merged_ch ();

    timestamp_ordered_queue_merge_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .merged    (merged_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    merge_scoreboard sb = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          rx_hold;
    int          idle_cycles;
    logic [TIME_W-1:0] now_ts;
    logic [TIME_W-1:0] queue_last_ts [NQ];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: random back-pressure, or a long hold while rx_hold is set
    initial merged_ch.ready = 1'b0;
    always @(negedge clk)
        merged_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // Monitor accepted results
    always @(posedge clk)
        if (rst_n && merged_ch.valid && merged_ch.ready)
            sb.check_result('{merged_ch.has_sample, merged_ch.status, merged_ch.out_queue,
                              merged_ch.out_time, merged_ch.out_payload, merged_ch.last});

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (merged_ch.valid && merged_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the core takes it
    task automatic send_request(logic kind, logic [QID_W-1:0] q, logic [GID_W-1:0] g,
                                logic [TIME_W-1:0] ts, logic [PAY_W-1:0] pay);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       = 1'b1;
        sample_ch.kind        = kind;
        sample_ch.queue_index = q;
        sample_ch.group_index = g;
        sample_ch.timestamp   = ts;
        sample_ch.payload     = pay;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_request(kind, q, g, ts, pay);
    endtask

    task automatic push(int q, logic [TIME_W-1:0] ts, logic [PAY_W-1:0] pay);
        send_request(KIND_PUSH, q[QID_W-1:0], GID_W'($urandom), ts, pay);
    endtask

    task automatic finish_group(int g);
        send_request(KIND_FINISH, QID_W'($urandom), g[GID_W-1:0], {$urandom, $urandom},
                     $urandom);
    endtask

    // Lower valid and wait until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random traffic: mostly in-order pushes near a shared clock, some noise
    task automatic random_phase(int count);
        int                q;
        int                r;
        logic [TIME_W-1:0] ts;
        for (int i = 0; i < count; i++)
        begin
            q = $urandom_range(NQ-1);
            r = $urandom_range(99);
            if (r < 2)
                finish_group($urandom_range(NG-1));
            else
            begin
                if (r < 7)
                    ts = {$urandom, $urandom};
                else if (r < 12)
                    ts = queue_last_ts[q] - $urandom_range(1, 3);
                else
                begin
                    now_ts = now_ts + $urandom_range(0, 4);
                    ts = now_ts + $urandom_range(0, 2);
                end
                if (ts >= queue_last_ts[q])
                    queue_last_ts[q] = ts;
                push(q, ts, $urandom);
            end
            if (i == count / 2)
                wait_drained();
        end
    endtask

    task automatic new_phase(logic [MASK_W-1:0] mask, logic [MAP_W-1:0] map);
        wait_drained();
        write_reg(CFG_ACTIVE_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_GROUP_MAP, map);
        now_ts = {$urandom, $urandom} >> $urandom_range(0, 63);
        foreach (queue_last_ts[q])
            queue_last_ts[q] = '0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.kind        = KIND_PUSH;
        sample_ch.queue_index = '0;
        sample_ch.group_index = '0;
        sample_ch.timestamp   = '0;
        sample_ch.payload     = '0;
        tx_idle_pct           = 0;
        rx_idle_pct           = 0;
        rx_hold               = 1'b0;
        idle_cycles           = 0;
        now_ts                = '0;
        foreach (queue_last_ts[q])
            queue_last_ts[q] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: nothing registered, then two groups of two queues
        push(0, 64'd5, 32'h1);
        finish_group(0);
        wait_drained();
        write_reg(CFG_ACTIVE_MASK, CFG_DATA_W'(8'h0F));
        write_reg(CFG_GROUP_MAP, 16'h0050);
        push(7, 64'd1, 32'h2);
        push(0, 64'd0, 32'h0);
        push(0, 64'd10, 32'hFFFF_FFFF);
        push(0, 64'd3, 32'h3);
        for (int k = 0; k < DEPTH - 2; k++)
            push(0, 64'd20 + k, k);
        push(0, 64'd40, 32'h4);
        push(2, 64'd15, 32'h5);
        push(3, 64'd12, 32'h6);
        push(1, 64'd22, 32'h7);
        push(1, 64'd22, 32'h8);
        push(2, {TIME_W{1'b1}}, 32'hA5A5_5A5A);
        finish_group(2);
        finish_group(0);
        push(1, 64'd50, 32'h9);
        push(3, 64'd2, 32'hA);
        finish_group(1);
        finish_group(1);

        // Sender busy, receiver slow
        tx_idle_pct = 24;
        rx_idle_pct = 73;
        new_phase(8'hF0, 16'($urandom));
        random_phase(90);

        // Sender slow, receiver busy; open with a long receiver hold
        tx_idle_pct = 73;
        rx_idle_pct = 24;
        new_phase(8'hFF, 16'hFFFF);
        rx_hold = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                rx_hold = 1'b0;
            end
        join_none
        tx_idle_pct = 0;
        random_phase(20);
        tx_idle_pct = 73;
        random_phase(70);

        // No idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        new_phase(8'($urandom), 16'($urandom));
        random_phase(70);

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/tqm_pkg.sv
hw/rtl/tqm_if.sv
hw/rtl/tqm_ram.sv
hw/rtl/timestamp_ordered_queue_merge_core.sv
hw/rtl/tqm_checker.sv
tb/tb_top.sv
